>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on clk_i, off while rst_ni is low.
`define MSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check, sampled on clk_i, off while rst_ni is low.
`define MSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/msq_pkg.sv
`timescale 1ns / 1ps

package msq_pkg;

  // Field widths of the item and result beats
  localparam int unsigned PID_W   = 8;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned COST_W  = 8;

  // Levels an enqueue can name with its level field
  localparam int unsigned MAX_LVL = 1 << LEVEL_W;

  // Default sizing
  localparam int unsigned DEF_NUM_PRIO   = 8;
  localparam int unsigned DEF_FIFO_DEPTH = 16;

  // Command queue between front and back end
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  // Register port
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned REG_SLOT_COST = 0;
  localparam logic [COST_W-1:0] SLOT_COST_RST = 8'd1;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_REJECT
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } eng_state_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [PID_W-1:0]   proc_id;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic [PID_W-1:0]   proc_id;
    logic [LEVEL_W-1:0] level;
    logic               dropped;
    logic               refilled;
  } rsp_t;

endpackage

>>> sv/multilevel_queue_slot_scheduler_unit.sv
// Multilevel queue scheduler with per-level slot budgets. Enqueue beats append a process id to
// the ring of their level (min(NUM_PRIO, 8) levels are reachable through the 3-bit level field);
// a full ring or an out-of-range level returns dropped. Dequeue beats pop the lowest non-empty
// level with budget left, charge it slot_cost (register at byte 0x0) and refill all budgets once
// when every non-empty level is spent. A front end classifies beats into a two-entry command
// queue, so input is taken while a result waits at the output register. In the back end a dequeue
// scans the levels one per cycle from level 0 and, when a refill is needed, scans them once more;
// a hit is then read from the id store through its registered read port. The id store has no
// clearing pass.
`timescale 1ns / 1ps

module multilevel_queue_slot_scheduler_unit import msq_pkg::*; #(
  parameter int unsigned NUM_PRIO   = DEF_NUM_PRIO,
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  // item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [PID_W-1:0]   proc_id_i,
  input  logic [LEVEL_W-1:0] level_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [PID_W-1:0]   out_proc_id_o,
  output logic [LEVEL_W-1:0] out_level_o,
  output logic               dropped_o,
  output logic               budgets_refilled_o
);

  logic [COST_W-1:0] slot_cost_q;
  logic              sel_slot_cost;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  rsp_t              rsp;

  // Register decode
  assign pready        = 1'b1;
  assign sel_slot_cost = (paddr[APB_AW-1:2] == (APB_AW - 2)'(REG_SLOT_COST));
  assign prdata        = sel_slot_cost ? APB_DW'(slot_cost_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cost_q <= SLOT_COST_RST;
    end else if (psel && penable && pwrite && pready && sel_slot_cost) begin
      slot_cost_q <= pwdata[COST_W-1:0];
    end
  end

  // Front end: accept and classify
  msq_cmd_queue #(
    .NUM_PRIO (NUM_PRIO)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .proc_id_i   (proc_id_i),
    .level_i     (level_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: rings, budgets, scan
  msq_level_engine #(
    .NUM_PRIO   (NUM_PRIO),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .slot_cost_i (slot_cost_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (rsp)
  );

  assign found_o            = rsp.found;
  assign out_proc_id_o      = rsp.proc_id;
  assign out_level_o        = rsp.level;
  assign dropped_o          = rsp.dropped;
  assign budgets_refilled_o = rsp.refilled;

endmodule

>>> sv/msq_cmd_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msq_cmd_queue import msq_pkg::*; #(
  parameter int unsigned NUM_PRIO = DEF_NUM_PRIO
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [PID_W-1:0]   proc_id_i,
  input  logic [LEVEL_W-1:0] level_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned NUM_LVL = (NUM_PRIO < MAX_LVL) ? NUM_PRIO : MAX_LVL;
  localparam int unsigned QIW     = $clog2(CMD_QUEUE_DEPTH);
  localparam int unsigned QCW     = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t             entry_q [CMD_QUEUE_DEPTH];
  logic [QIW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QIW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  cmd_t             cmd_new;
  logic             push;

  // Classify the incoming beat
  always_comb begin
    cmd_new.proc_id = proc_id_i;
    cmd_new.level   = level_i;
    if (op_i) begin
      cmd_new.op = CMD_DEQ;
    end else if ({1'b0, level_i} < (LEVEL_W + 1)'(NUM_LVL)) begin
      cmd_new.op = CMD_ENQ;
    end else begin
      cmd_new.op = CMD_REJECT;
    end
  end

  assign in_ready_o  = (cnt_q != QCW'(CMD_QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QIW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QIW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QIW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QIW'(1);
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  `MSQ_ASSERT_IMP(a_pop_nonempty, cmd_pop_i, cnt_q != '0, "pop from empty command queue")
  `MSQ_ASSERT(a_cnt_bound, cnt_q <= QCW'(CMD_QUEUE_DEPTH), "command queue overfilled")

endmodule

>>> sv/msq_level_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msq_level_engine import msq_pkg::*; #(
  parameter int unsigned NUM_PRIO   = DEF_NUM_PRIO,
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  input  logic [COST_W-1:0] slot_cost_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              rsp_o
);

  localparam int unsigned NUM_LVL   = (NUM_PRIO < MAX_LVL) ? NUM_PRIO : MAX_LVL;
  localparam int unsigned LW        = $clog2(NUM_LVL);
  localparam int unsigned PW        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNTW      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned BW        = $clog2(NUM_PRIO + 1);
  localparam int unsigned CW        = (BW > COST_W) ? BW : COST_W;
  localparam int unsigned MEM_DEPTH = NUM_LVL * FIFO_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Per-level bookkeeping
  logic [PW-1:0]   head_q   [NUM_LVL];
  logic [PW-1:0]   tail_q   [NUM_LVL];
  logic [CNTW-1:0] cnt_q    [NUM_LVL];
  logic [BW-1:0]   budget_q [NUM_LVL];

  // Id store, one ring per level
  logic [PID_W-1:0] mem [MEM_DEPTH];
  logic [PID_W-1:0] rd_data_q;

  eng_state_e    st_q, st_d;
  logic [LW-1:0] lv_q, lv_d;
  logic          starved_q, starved_d;
  logic          refilled_q, refilled_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          out_free;
  logic          load_out;
  logic [LW-1:0] enq_lv;
  logic          enq_we;
  logic          deq_take;
  logic          refill;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          cur_nonempty;
  logic          hit;
  logic          scan_last;
  logic [CW-1:0] bud_ext;
  logic [CW-1:0] cost_ext;
  logic [BW-1:0] bud_new;

  assign out_free     = !out_valid_q || out_ready_i;
  assign enq_lv       = cmd_i.level[LW-1:0];
  assign cur_nonempty = (cnt_q[lv_q] != '0);
  assign hit          = cur_nonempty && (budget_q[lv_q] != '0);
  assign scan_last    = (lv_q == LW'(NUM_LVL - 1));
  assign wr_addr      = AW'(enq_lv) * AW'(FIFO_DEPTH) + AW'(tail_q[enq_lv]);
  assign rd_addr      = AW'(lv_q) * AW'(FIFO_DEPTH) + AW'(head_q[lv_q]);

  // Charge the slot cost, saturating at zero
  assign bud_ext  = CW'(budget_q[lv_q]);
  assign cost_ext = CW'(slot_cost_i);
  assign bud_new  = (bud_ext > cost_ext) ? BW'(bud_ext - cost_ext) : '0;

  // Sequencer: next state and datapath strobes
  always_comb begin
    st_d       = st_q;
    lv_d       = lv_q;
    starved_d  = starved_q;
    refilled_d = refilled_q;
    cmd_pop_o  = 1'b0;
    load_out   = 1'b0;
    enq_we     = 1'b0;
    deq_take   = 1'b0;
    refill     = 1'b0;
    rd_en      = 1'b0;
    rsp_d      = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_DEQ: begin
              cmd_pop_o  = 1'b1;
              lv_d       = '0;
              starved_d  = 1'b0;
              refilled_d = 1'b0;
              st_d       = ST_SCAN;
            end
            CMD_ENQ: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                load_out  = 1'b1;
                if (cnt_q[enq_lv] < CNTW'(FIFO_DEPTH)) begin
                  enq_we      = 1'b1;
                  rsp_d.found = 1'b1;
                end else begin
                  rsp_d.dropped = 1'b1;
                end
              end
            end
            default: begin
              // level outside the configured range
              if (out_free) begin
                cmd_pop_o     = 1'b1;
                load_out      = 1'b1;
                rsp_d.dropped = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          deq_take = 1'b1;
          rd_en    = 1'b1;
          st_d     = ST_READ;
        end else if (scan_last) begin
          if ((starved_q || cur_nonempty) && !refilled_q) begin
            refill     = 1'b1;
            refilled_d = 1'b1;
            starved_d  = 1'b0;
            lv_d       = '0;
          end else if (out_free) begin
            // every level empty
            load_out = 1'b1;
            st_d     = ST_IDLE;
          end
        end else begin
          starved_d = starved_q || cur_nonempty;
          lv_d      = lv_q + LW'(1);
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out       = 1'b1;
          rsp_d.found    = 1'b1;
          rsp_d.proc_id  = rd_data_q;
          rsp_d.level    = LEVEL_W'(lv_q);
          rsp_d.refilled = refilled_q;
          st_d           = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      lv_q        <= '0;
      starved_q   <= 1'b0;
      refilled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      lv_q        <= lv_d;
      starved_q   <= starved_d;
      refilled_q  <= refilled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rsp_q <= rsp_d;
    end
  end

  // Ring pointers, fill counts and budgets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LVL; i++) begin
        head_q[i]   <= '0;
        tail_q[i]   <= '0;
        cnt_q[i]    <= '0;
        budget_q[i] <= BW'(NUM_PRIO - i);
      end
    end else begin
      if (enq_we) begin
        tail_q[enq_lv] <= ptr_inc(tail_q[enq_lv]);
        cnt_q[enq_lv]  <= cnt_q[enq_lv] + CNTW'(1);
      end
      if (deq_take) begin
        head_q[lv_q]   <= ptr_inc(head_q[lv_q]);
        cnt_q[lv_q]    <= cnt_q[lv_q] - CNTW'(1);
        budget_q[lv_q] <= bud_new;
      end
      if (refill) begin
        for (int i = 0; i < NUM_LVL; i++) begin
          budget_q[i] <= BW'(NUM_PRIO - i);
        end
      end
    end
  end

  // Id store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (enq_we) begin
      mem[wr_addr] <= cmd_i.proc_id;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  `MSQ_ASSERT(a_retry_hits, !(st_q == ST_SCAN && refilled_q && scan_last && !hit), "refill retry found no level")
  `MSQ_ASSERT_IMP(a_flags_excl, out_valid_q, !(rsp_q.dropped && (rsp_q.found || rsp_q.refilled)), "dropped beat carries dequeue flags")
  `MSQ_ASSERT_NXT(a_read_result, st_q == ST_READ && out_free, out_valid_q && rsp_q.found, "dequeue hit lost its result")

endmodule

>>> verif/msq_sched_tb_pkg.sv
`timescale 1ns / 1ps

package msq_sched_tb_pkg;
  import msq_pkg::*;

  // Encoding of the op field on the item channel
  localparam bit OP_ENQ = 1'b0;
  localparam bit OP_DEQ = 1'b1;

  // Sizing of the instance under test (defaults)
  localparam int unsigned LEVELS     = DEF_NUM_PRIO;
  localparam int unsigned RING_DEPTH = DEF_FIFO_DEPTH;

  // Only this many failures get printed, the rest are counted
  localparam int unsigned REPORT_CAP = 10;

  // Mirror of the run queues and budgets, plus the results still owed by the block
  class dispatch_scoreboard;
    logic [PID_W-1:0]  ready_ids [LEVELS][$];
    int unsigned       budget [LEVELS];
    logic [COST_W-1:0] slot_cost;
    rsp_t              expected_rsp [$];
    int unsigned       errors;

    function new();
      refill();
      slot_cost = SLOT_COST_RST;
      errors = 0;
    endfunction

    function void refill();
      for (int lv = 0; lv < LEVELS; lv++) begin
        budget[lv] = LEVELS - lv;
      end
    endfunction

    // First non-empty level with budget left, LEVELS if none;
    // starved flags a non-empty level that was skipped for lack of budget
    function int unsigned pick_level(output bit starved);
      starved = 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        if (ready_ids[lv].size() != 0) begin
          if (budget[lv] > 0) return lv;
          starved = 1'b1;
        end
      end
      return LEVELS;
    endfunction

    function void set_cost(logic [COST_W-1:0] cost);
      slot_cost = cost;
    endfunction

    function int unsigned outstanding();
      return expected_rsp.size();
    endfunction

    // Accepted item beat: update the mirror and queue the result it must produce
    function void note_item(bit op, logic [PID_W-1:0] pid, logic [LEVEL_W-1:0] lvl);
      rsp_t        want;
      int unsigned lv;
      bit          starved;
      want = '0;
      if (op == OP_ENQ) begin
        if (lvl < LEVELS && ready_ids[lvl].size() < RING_DEPTH) begin
          ready_ids[lvl].push_back(pid);
          want.found = 1'b1;
        end else begin
          want.dropped = 1'b1;
        end
      end else begin
        lv = pick_level(starved);
        // every non-empty level spent: refill all, scan once more
        if (lv == LEVELS && starved) begin
          refill();
          want.refilled = 1'b1;
          lv = pick_level(starved);
        end
        if (lv < LEVELS) begin
          want.found   = 1'b1;
          want.proc_id = ready_ids[lv].pop_front();
          want.level   = LEVEL_W'(lv);
          budget[lv]   = (budget[lv] > slot_cost) ? budget[lv] - slot_cost : 0;
        end
      end
      expected_rsp.push_back(want);
    endfunction

    // Accepted result beat: compare against the oldest expectation
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("unexpected result: found=%0b id=%0d level=%0d dropped=%0b refilled=%0b",
                   got.found, got.proc_id, got.level, got.dropped, got.refilled);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.found !== want.found || got.proc_id !== want.proc_id ||
          got.level !== want.level || got.dropped !== want.dropped ||
          got.refilled !== want.refilled) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("result mismatch: expected found=%0b id=%0d level=%0d dropped=%0b refilled=%0b",
                   want.found, want.proc_id, want.level, want.dropped, want.refilled);
          $display("                 actual   found=%0b id=%0d level=%0d dropped=%0b refilled=%0b",
                   got.found, got.proc_id, got.level, got.dropped, got.refilled);
        end
      end
    endfunction
  endclass

endpackage

>>> verif/multilevel_queue_slot_scheduler_unit_test.sv
`timescale 1ns / 1ps

module multilevel_queue_slot_scheduler_unit_test;
  import msq_pkg::*;
  import msq_sched_tb_pkg::*;

  // Cycles to let pass after the last result; covers the longest dequeue with a rescan
  localparam int unsigned SETTLE_CYCLES = 2 * LEVELS + 4;
  localparam int          PICK_COST     = -1;
  localparam int unsigned NUM_PHASES    = 9;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [APB_AW-1:0]  paddr       = '0;
  logic [APB_DW-1:0]  pwdata      = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               op_i        = 1'b0;
  logic [PID_W-1:0]   proc_id_i   = '0;
  logic [LEVEL_W-1:0] level_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               found_o;
  logic [PID_W-1:0]   out_proc_id_o;
  logic [LEVEL_W-1:0] out_level_o;
  logic               dropped_o;
  logic               budgets_refilled_o;
  logic [10:0]        stall_tick  = '0;

  // Per phase: slot cost, enqueue share in percent, mask on the level field
  int                 phase_cost [NUM_PHASES] = '{255, 0, 2, 3, 8, PICK_COST, 1, PICK_COST, 254};
  int unsigned        phase_enq  [NUM_PHASES] = '{60, 55, 70, 40, 55, 50, 65, 45, 52};
  logic [LEVEL_W-1:0] phase_mask [NUM_PHASES] =
    '{3'b111, 3'b111, 3'b011, 3'b111, 3'b110, 3'b111, 3'b101, 3'b111, 3'b001};

  dispatch_scoreboard sb = new();

  multilevel_queue_slot_scheduler_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .proc_id_i          (proc_id_i),
    .level_i            (level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .out_proc_id_o      (out_proc_id_o),
    .out_level_o        (out_level_o),
    .dropped_o          (dropped_o),
    .budgets_refilled_o (budgets_refilled_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check accepted beats, stall on a rotating pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result('{found: found_o, proc_id: out_proc_id_o, level: out_level_o,
                          dropped: dropped_o, refilled: budgets_refilled_o});
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[10:9])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= (stall_tick[1:0] != 2'd0);
        2'd2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= stall_tick[4];
      endcase
    end
  end

  // Present one item beat and hold it until accepted; valid stays high on return
  task automatic push_item(bit op, logic [PID_W-1:0] pid, logic [LEVEL_W-1:0] lvl);
    in_valid_i <= 1'b1;
    op_i       <= op;
    proc_id_i  <= pid;
    level_i    <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(op, pid, lvl);
  endtask

  task automatic idle_input(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every owed result is out, then let the back end settle
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == APB_AW'(REG_SLOT_COST * 4)) sb.set_cost(data[COST_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic in bursts; gaps, back-to-back stretches and the odd full drain
  task automatic run_phase(int unsigned n_items, int unsigned enq_pct,
                           logic [LEVEL_W-1:0] lvl_mask);
    int unsigned sent;
    int unsigned burst;
    bit          op;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      while (burst != 0 && sent < n_items) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        push_item(op, PID_W'($urandom), LEVEL_W'($urandom) & lvl_mask);
        burst--;
        sent++;
      end
      if ($urandom_range(0, 24) == 0) wait_results();
      else if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 8));
    end
  endtask

  // Main sequence
  initial begin
    int cost;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset slot cost: empty dequeue, ring overflow, extreme ids and levels,
    // budget exhaustion and a refill
    push_item(OP_DEQ, '0, '0);
    for (int k = 0; k < RING_DEPTH + 1; k++) push_item(OP_ENQ, PID_W'(k * 15), 3'd6);
    push_item(OP_ENQ, 8'h00, 3'd0);
    push_item(OP_ENQ, 8'hFF, 3'd7);
    repeat (5) push_item(OP_DEQ, 8'hFF, 3'd7);

    // Random phases, each under its own slot cost
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results();
      cost = (phase_cost[ph] == PICK_COST) ? int'($urandom_range(1, 255)) : phase_cost[ph];
      write_reg(APB_AW'(REG_SLOT_COST * 4), APB_DW'(cost));
      run_phase(200, phase_enq[ph], phase_mask[ph]);
    end

    wait_results();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> multilevel_queue_slot_scheduler_unit.f
+incdir+sv
sv/msq_pkg.sv
sv/msq_cmd_queue.sv
sv/msq_level_engine.sv
sv/multilevel_queue_slot_scheduler_unit.sv
verif/msq_sched_tb_pkg.sv
verif/multilevel_queue_slot_scheduler_unit_test.sv
